// ----- sv/vwalu_pkg.sv -----
package vwalu_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned XLEN = 64;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_SUB  = 5'd1,
    CMD_MUL  = 5'd2,
    CMD_DIVU = 5'd3,
    CMD_DIVS = 5'd4,
    CMD_MODU = 5'd5,
    CMD_SHL  = 5'd6,
    CMD_AND  = 5'd7,
    CMD_OR   = 5'd8,
    CMD_XOR  = 5'd9,
    CMD_NOT  = 5'd10,
    CMD_ZX   = 5'd11,
    CMD_SX   = 5'd12,
    CMD_EQ   = 5'd13,
    CMD_NE   = 5'd14,
    CMD_LES  = 5'd15,
    CMD_LEU  = 5'd16,
    CMD_LTS  = 5'd17,
    CMD_LTU  = 5'd18
  } cmd_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [6:0]  width;
    logic [6:0]  source_width;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        divide_error;
  } out_beat_t;

  // low-w-bits mask, w in 1..64
  function automatic logic [63:0] wmask(input logic [6:0] w);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) begin
      m[i] = (7'(i) < w);
    end
    return m;
  endfunction

endpackage

// ----- sv/vwalu_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module vwalu_div #(
  parameter int unsigned N = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [N-1:0] in_num,
  input  logic [N-1:0] in_den,
  output logic [N-1:0] out_quo,
  output logic [N-1:0] out_rem
);
  import vwalu_pkg::*;

  logic [N-1:0] num_r [N+1];
  logic [N-1:0] den_r [N+1];
  logic [N-1:0] rem_r [N+1];
  logic [N:0]   vld_r;

  always_comb begin
    num_r[0] = in_num;
    den_r[0] = in_den;
    rem_r[0] = '0;
    vld_r[0] = in_valid;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0] trial;
    logic [N:0] diff;
    assign trial = {rem_r[k], num_r[k][N-1]};
    assign diff  = trial - {1'b0, den_r[k]};

    // one restoring step, quotient bit shifts into the numerator word
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      if (vld_r[k]) begin
        den_r[k+1] <= den_r[k];
        if (!diff[N]) begin
          rem_r[k+1] <= diff[N-1:0];
          num_r[k+1] <= {num_r[k][N-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= trial[N-1:0];
          num_r[k+1] <= {num_r[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_quo = num_r[N];
  assign out_rem = rem_r[N];

endmodule

// ----- sv/variable_width_ir_alu_unit.sv -----
// Variable-width integer ALU: one operation is accepted every clock (busy is
// always low), and its result appears on out_valid through the same register
// path for every command. The divider sets that path's length: it is a
// pipeline with one restoring quotient bit per stage, and the other operations
// are delayed to match.
// The receiver cannot stall; each result is shown for one cycle only.
module variable_width_ir_alu_unit #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vwalu_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  output vwalu_pkg::out_beat_t out_beat
);
  import vwalu_pkg::*;

  localparam int unsigned LAT = XLEN;

  assign busy = 1'b0;

  // ---------------- stage 1: decode widths, mask operands
  logic        v1_r;
  cmd_t        cmd1_r;
  logic [6:0]  w1_r;
  logic [63:0] m1_r, ms1_r, a1_r, b1_r, sb1_r;

  logic [6:0]  w_c, s_c;
  logic [63:0] m_c;
  always_comb begin
    w_c = in_beat.width;
    if (w_c == 7'd0) w_c = 7'd1;
    if (w_c > 7'(MAX_WIDTH)) w_c = 7'(MAX_WIDTH);
    s_c = in_beat.source_width;
    if (s_c == 7'd0) s_c = 7'd1;
    if (s_c > 7'(MAX_WIDTH)) s_c = 7'(MAX_WIDTH);
    if (s_c > w_c) s_c = w_c;
    m_c = wmask(w_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    cmd1_r <= cmd_t'(in_beat.command);
    w1_r   <= w_c;
    m1_r   <= m_c;
    ms1_r  <= wmask(s_c);
    a1_r   <= in_beat.operand_a & m_c;
    b1_r   <= in_beat.operand_b & m_c;
    sb1_r  <= 64'd1 << (w_c - 7'd1);
  end

  // ---------------- stage 2: simple ops, divider operand prep, partial products
  logic        v2_r;
  cmd_t        cmd2_r;
  logic [63:0] m2_r, r2_r;
  logic        na2_r, nb2_r, bz2_r;
  logic [63:0] pll_r, plh_r, phl_r;

  logic [63:0] r_c;
  logic        na_c, nb_c;
  logic [63:0] da_c, db_c;
  always_comb begin
    r_c = '0;
    case (cmd1_r)
      CMD_ADD: r_c = a1_r + b1_r;
      CMD_SUB: r_c = a1_r - b1_r;
      CMD_SHL: r_c = (b1_r >= 64'(w1_r)) ? 64'd0 : (a1_r << b1_r[5:0]);
      CMD_AND: r_c = a1_r & b1_r;
      CMD_OR:  r_c = a1_r | b1_r;
      CMD_XOR: r_c = a1_r ^ b1_r;
      CMD_NOT: r_c = ~a1_r;
      CMD_ZX:  r_c = a1_r & ms1_r;
      CMD_SX:  r_c = ((a1_r & (ms1_r ^ (ms1_r >> 1))) != 0) ?
                     (a1_r | ~ms1_r) : (a1_r & ms1_r);
      CMD_EQ:  r_c = 64'(a1_r == b1_r);
      CMD_NE:  r_c = 64'(a1_r != b1_r);
      CMD_LES: r_c = 64'((a1_r ^ sb1_r) <= (b1_r ^ sb1_r));
      CMD_LEU: r_c = 64'(a1_r <= b1_r);
      CMD_LTS: r_c = 64'((a1_r ^ sb1_r) < (b1_r ^ sb1_r));
      CMD_LTU: r_c = 64'(a1_r < b1_r);
      default: r_c = '0;
    endcase
    na_c = (cmd1_r == CMD_DIVS) && ((a1_r & sb1_r) != 0);
    nb_c = (cmd1_r == CMD_DIVS) && ((b1_r & sb1_r) != 0);
    da_c = na_c ? ((64'd0 - a1_r) & m1_r) : a1_r;
    db_c = nb_c ? ((64'd0 - b1_r) & m1_r) : b1_r;
  end

  logic        dv_r;
  logic [63:0] dn_r, dd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      dv_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
      dv_r <= v1_r;
    end
    cmd2_r <= cmd1_r;
    m2_r   <= m1_r;
    r2_r   <= r_c;
    na2_r  <= na_c;
    nb2_r  <= nb_c;
    bz2_r  <= (b1_r == 64'd0);
    dn_r   <= da_c;
    dd_r   <= (b1_r == 64'd0) ? 64'd1 : db_c;
    pll_r  <= 64'(a1_r[31:0]) * 64'(b1_r[31:0]);
    plh_r  <= 64'(a1_r[31:0]) * 64'(b1_r[63:32]);
    phl_r  <= 64'(a1_r[63:32]) * 64'(b1_r[31:0]);
  end

  // product low 64 bits, then delay line to divider latency
  logic [63:0] prod_c;
  assign prod_c = pll_r + {plh_r[31:0] + phl_r[31:0], 32'd0};

  logic [63:0] quo, rem;
  vwalu_div #(.N(LAT)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(dv_r),
    .in_num  (dn_r),
    .in_den  (dd_r),
    .out_quo (quo),
    .out_rem (rem)
  );

  // side delay line: lane k holds the item entering divider stage k
  logic [LAT:0] dv_d;
  cmd_t         dcmd  [LAT+1];
  logic [63:0]  dm    [LAT+1];
  logic [63:0]  dr    [LAT+1];
  logic [LAT:0] dneg, dbz;

  always_comb begin
    dv_d[0]  = v2_r;
    dcmd[0]  = cmd2_r;
    dm[0]    = m2_r;
    dr[0]    = (cmd2_r == CMD_MUL) ? prod_c : r2_r;
    dneg[0]  = na2_r ^ nb2_r;
    dbz[0]   = bz2_r;
  end

  for (genvar k = 0; k < LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_d[k+1] <= 1'b0;
      end else begin
        dv_d[k+1] <= dv_d[k];
      end
      dcmd[k+1] <= dcmd[k];
      dm[k+1]   <= dm[k];
      dr[k+1]   <= dr[k];
      dneg[k+1] <= dneg[k];
      dbz[k+1]  <= dbz[k];
    end
  end

  // ---------------- final stage: pick result, mask, flag
  logic        is_div;
  logic [63:0] q_c, f_c;
  always_comb begin
    is_div = (dcmd[LAT] == CMD_DIVU) || (dcmd[LAT] == CMD_DIVS) ||
             (dcmd[LAT] == CMD_MODU);
    q_c = dneg[LAT] ? (64'd0 - quo) : quo;
    f_c = dr[LAT];
    if (is_div) begin
      if (dbz[LAT]) f_c = '0;
      else if (dcmd[LAT] == CMD_MODU) f_c = rem;
      else f_c = q_c;
    end
  end

  logic      ov_r;
  out_beat_t ob_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_d[LAT];
    end
    ob_r.result_value <= f_c & dm[LAT];
    ob_r.divide_error <= is_div && dbz[LAT];
  end

  assign out_valid = ov_r;
  assign out_beat  = ob_r;

endmodule
